// ===== hdl/i2a_pkg.sv =====
// Package for the integer to ASCII formatter: beat types, format codes,
// character constants and the digit-to-character mapping. No dependencies.
`default_nettype none

package i2a_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned DIGIT_W    = 4;
    localparam int unsigned DEC_DIGITS = 10;
    localparam int unsigned BCD_W      = DEC_DIGITS * DIGIT_W;

    // Format codes carried in the action field.
    localparam logic [1:0] ACT_SDEC  = 2'd0;
    localparam logic [1:0] ACT_UDEC  = 2'd1;
    localparam logic [1:0] ACT_HEXLO = 2'd2;
    localparam logic [1:0] ACT_HEXUP = 2'd3;

    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;

    localparam logic [3:0] COUNT_DEC = 4'd10;
    localparam logic [3:0] COUNT_HEX = 4'd8;
    localparam logic [3:0] MAX_CHARS = 4'd11;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  action;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] character;
        logic [3:0] char_count;
        logic       last;
    } t_out_beat;

    function automatic logic [7:0] digit_char(input logic [3:0] digit, input logic upper);
        logic [7:0] base;
        if (digit < 4'd10) begin
            digit_char = CHAR_ZERO + {4'd0, digit};
        end else begin
            base       = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
            digit_char = base + {4'd0, digit} - 8'd10;
        end
    endfunction

endpackage

`default_nettype wire

// ===== hdl/i2a_dabble.sv =====
// Bit-serial binary to BCD converter (shift and add three), one bit a cycle.
// Depends on i2a_pkg.
`default_nettype none

module i2a_dabble (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [i2a_pkg::WORD_W-1:0] i_bin,
    output logic                           o_done,
    output logic [i2a_pkg::BCD_W-1:0]      o_bcd
);

    localparam int unsigned SHIFT_W = i2a_pkg::BCD_W + i2a_pkg::WORD_W;
    localparam int unsigned STEP_W  = $clog2(i2a_pkg::WORD_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(i2a_pkg::WORD_W - 1);

    logic [SHIFT_W-1:0] r_shift, n_shift;
    logic [STEP_W-1:0]  r_step;
    logic               r_busy;
    logic               r_done;

    // Each BCD digit of five or more gets three added before the shift.
    always_comb begin
        logic [3:0] dig;
        n_shift = r_shift;
        for (int d = 0; d < int'(i2a_pkg::DEC_DIGITS); d++) begin
            dig = r_shift[i2a_pkg::WORD_W + d*4 +: 4];
            if (dig >= 4'd5) begin
                n_shift[i2a_pkg::WORD_W + d*4 +: 4] = dig + 4'd3;
            end
        end
        n_shift = {n_shift[SHIFT_W-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= {{i2a_pkg::BCD_W{1'b0}}, i_bin};
        end else if (r_busy) begin
            r_shift <= n_shift;
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_shift[SHIFT_W-1:i2a_pkg::WORD_W];

endmodule

`default_nettype wire

// ===== hdl/integer_to_ascii_formatter.sv =====
// Top level of the integer to ASCII formatter: takes a word and a format and
// sends its text one character per beat. Depends on i2a_pkg and i2a_dabble.
//
//   channel   direction   handshake                 payload
//   in        receive     i_in_valid / o_in_stall   i2a_pkg::t_in_beat
//   out       send        o_out_valid / i_out_stall i2a_pkg::t_out_beat
//
// Hex words go straight to the digit register; decimal words first pass the
// bit-serial BCD converter. Emission then walks the digit register one digit a
// cycle from the top while the output is not stalled, dropping each leading
// zero but the final digit without a beat.
// Reset is synchronous, active low. A stalled output holds its beat and
// pauses emission; a new item is taken once the last beat sits in the output
// register.
`default_nettype none

module integer_to_ascii_formatter (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire i2a_pkg::t_in_beat  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output i2a_pkg::t_out_beat      o_out_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]                 r_state;
    logic [i2a_pkg::BCD_W-1:0]  r_digits;
    logic [3:0]                 r_left;
    logic [3:0]                 r_count;
    logic                       r_minus;
    logic                       r_lead;
    logic                       r_upper;
    logic                       r_out_valid;
    i2a_pkg::t_out_beat         r_out;

    logic                       in_take;
    logic                       out_free;
    logic                       neg;
    logic [i2a_pkg::WORD_W-1:0] mag;
    logic                       dab_start;
    logic                       dab_done;
    logic [i2a_pkg::BCD_W-1:0]  dab_bcd;
    logic [3:0]                 top_digit;
    logic                       skip_zero;
    logic                       beat_go;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_take    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign neg        = (i_in_data.action == i2a_pkg::ACT_SDEC) && i_in_data.value[31];
    assign mag        = neg ? (~i_in_data.value + 32'd1) : i_in_data.value;
    assign dab_start  = in_take && !i_in_data.action[1];
    assign top_digit  = r_digits[i2a_pkg::BCD_W-1 -: 4];
    // A leading zero is dropped without a beat, except in the final position.
    assign skip_zero  = r_lead && top_digit == 4'd0 && r_left != 4'd1;
    assign beat_go    = (r_state == S_EMIT) && out_free && (r_minus || !skip_zero);

    i2a_dabble u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dab_start),
        .i_bin   (mag),
        .o_done  (dab_done),
        .o_bcd   (dab_bcd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_minus     <= 1'b0;
            r_out_valid <= 1'b0;
            r_left      <= '0;
            r_count     <= '0;
            r_lead      <= 1'b0;
        end else begin
            if (beat_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_minus <= neg;
                        r_count <= '0;
                        r_lead  <= 1'b1;
                        if (i_in_data.action[1]) begin
                            r_left  <= i2a_pkg::COUNT_HEX;
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_CONV;
                        end
                    end
                end
                S_CONV: begin
                    if (dab_done) begin
                        r_left  <= i2a_pkg::COUNT_DEC;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        if (r_minus) begin
                            r_minus <= 1'b0;
                            r_count <= r_count + 4'd1;
                        end else if (skip_zero) begin
                            r_left <= r_left - 4'd1;
                        end else begin
                            r_lead  <= 1'b0;
                            r_left  <= r_left - 4'd1;
                            r_count <= r_count + 4'd1;
                            if (r_left == 4'd1) begin
                                r_state <= S_IDLE;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Digit register and output beat payload.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_upper <= (i_in_data.action == i2a_pkg::ACT_HEXUP);
            if (i_in_data.action[1]) begin
                r_digits <= {i_in_data.value, {(i2a_pkg::BCD_W - i2a_pkg::WORD_W){1'b0}}};
            end
        end else if (r_state == S_CONV && dab_done) begin
            r_digits <= dab_bcd;
        end else if (r_state == S_EMIT && out_free) begin
            if (r_minus) begin
                r_out.character  <= i2a_pkg::CHAR_MINUS;
                r_out.char_count <= r_count + 4'd1;
                r_out.last       <= 1'b0;
            end else begin
                r_digits <= {r_digits[i2a_pkg::BCD_W-5:0], 4'd0};
                if (!skip_zero) begin
                    r_out.character  <= i2a_pkg::digit_char(top_digit, r_upper);
                    r_out.char_count <= r_count + 4'd1;
                    r_out.last       <= (r_left == 4'd1);
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_emit_has_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT |-> r_left != 4'd0)
        else $error("emission running with no digits left");

    a_idle_no_minus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !r_minus)
        else $error("minus sign still pending when idle");

    a_minus_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_out.character == i2a_pkg::CHAR_MINUS
            |-> r_out.char_count == 4'd1 && !r_out.last)
        else $error("minus sign not the first of several characters");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_out.char_count != 4'd0 && r_out.char_count <= i2a_pkg::MAX_CHARS)
        else $error("character count out of range");

    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT && out_free && !r_minus && r_left == 4'd1 |=> r_state == S_IDLE)
        else $error("final digit did not end the item");

endmodule

`default_nettype wire

// ===== test/integer_to_ascii_formatter_tb.sv =====
// Self-checking testbench for integer_to_ascii_formatter: a directed table of words
// and formats, then random words, each character beat checked against its table text or a local predictor.
// Depends on i2a_pkg and the formatter RTL only.
module integer_to_ascii_formatter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIR_N      = 24;
    localparam int RAND_N     = 196;
    localparam int CALM_TAIL  = 40;
    localparam int MAX_REPORT = 10;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    i2a_pkg::t_in_beat  i_in_data   = '0;
    logic               i_out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    i2a_pkg::t_out_beat o_out_data;

    // Characters still owed by the block, oldest first.
    i2a_pkg::t_out_beat pending_chars [$];
    int                 mismatch_count = 0;
    bit                 sender_gaps_on = 1'b0;
    bit                 stall_bursts_on = 1'b0;

    // Directed words; a non-empty text is the exact expected output,
    // an empty one defers to the predictor.
    i2a_pkg::t_in_beat dir_beats [DIR_N] = '{
        {32'h0000_0000, i2a_pkg::ACT_SDEC},  {32'h0000_0000, i2a_pkg::ACT_UDEC},
        {32'h0000_0000, i2a_pkg::ACT_HEXLO}, {32'h0000_0000, i2a_pkg::ACT_HEXUP},
        {32'h8000_0000, i2a_pkg::ACT_SDEC},  {32'h7FFF_FFFF, i2a_pkg::ACT_SDEC},
        {32'hFFFF_FFFF, i2a_pkg::ACT_SDEC},  {32'hFFFF_FFFF, i2a_pkg::ACT_UDEC},
        {32'hFFFF_FFFF, i2a_pkg::ACT_HEXLO}, {32'hFFFF_FFFF, i2a_pkg::ACT_HEXUP},
        {32'h8000_0000, i2a_pkg::ACT_UDEC},  {32'h8000_0000, i2a_pkg::ACT_HEXUP},
        {32'h0000_0001, i2a_pkg::ACT_SDEC},  {32'h0000_0009, i2a_pkg::ACT_UDEC},
        {32'h0000_000A, i2a_pkg::ACT_UDEC},  {32'h0000_000F, i2a_pkg::ACT_HEXUP},
        {32'h0000_0010, i2a_pkg::ACT_HEXLO}, {32'hABCD_EF01, i2a_pkg::ACT_HEXLO},
        {32'hABCD_EF01, i2a_pkg::ACT_HEXUP}, {32'h3B9A_CA00, i2a_pkg::ACT_UDEC},
        {32'hC465_3600, i2a_pkg::ACT_SDEC},  {32'h1234_5678, i2a_pkg::ACT_SDEC},
        {32'hDEAD_BEEF, i2a_pkg::ACT_SDEC},  {32'h5A5A_5A5A, i2a_pkg::ACT_HEXLO}
    };
    string dir_texts [DIR_N] = '{
        "0",           "0",
        "0",           "0",
        "-2147483648", "2147483647",
        "-1",          "4294967295",
        "ffffffff",    "FFFFFFFF",
        "2147483648",  "80000000",
        "1",           "9",
        "10",          "F",
        "10",          "abcdef01",
        "ABCDEF01",    "1000000000",
        "-1000000000", "",
        "",            ""
    };

    integer_to_ascii_formatter u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Works out the character beats for one word and queues them.
    function automatic void predict_text(input i2a_pkg::t_in_beat beat);
        logic [31:0]        mag;
        logic [31:0]        rem;
        logic [3:0]         nib;
        logic [7:0]         digits [11];
        logic [7:0]         letter_a;
        logic               minus;
        int                 ndig;
        int                 total;
        int                 k;
        i2a_pkg::t_out_beat ob;
        mag      = beat.value;
        minus    = 1'b0;
        ndig     = 0;
        letter_a = (beat.action == i2a_pkg::ACT_HEXUP) ? i2a_pkg::CHAR_UPPER_A
                                                        : i2a_pkg::CHAR_LOWER_A;
        if (beat.action == i2a_pkg::ACT_SDEC || beat.action == i2a_pkg::ACT_UDEC) begin
            // The most negative word wraps to its own bit pattern, read as unsigned.
            if (beat.action == i2a_pkg::ACT_SDEC && beat.value[31]) begin
                minus = 1'b1;
                mag   = ~beat.value + 32'd1;
            end
            do begin
                rem          = mag % 32'd10;
                digits[ndig] = i2a_pkg::CHAR_ZERO + rem[7:0];
                mag          = mag / 32'd10;
                ndig++;
            end while (mag != 32'd0);
        end else begin
            do begin
                nib = mag[3:0];
                if (nib < 4'd10) begin
                    digits[ndig] = i2a_pkg::CHAR_ZERO + {4'd0, nib};
                end else begin
                    digits[ndig] = letter_a + {4'd0, nib} - 8'd10;
                end
                mag = mag >> 4;
                ndig++;
            end while (mag != 32'd0);
        end
        total = ndig + (minus ? 1 : 0);
        k     = 0;
        if (minus) begin
            k++;
            ob.character  = i2a_pkg::CHAR_MINUS;
            ob.char_count = 4'd1;
            ob.last       = (total == 1);
            pending_chars.push_back(ob);
        end
        for (int i = ndig - 1; i >= 0; i--) begin
            k++;
            ob.character  = digits[i];
            ob.char_count = k[3:0];
            ob.last       = (k == total);
            pending_chars.push_back(ob);
        end
    endfunction

    // Presents one word, holding it until the block takes it, then queues its text.
    task automatic send_word(input i2a_pkg::t_in_beat beat, input string text);
        i2a_pkg::t_out_beat ob;
        if (sender_gaps_on && $urandom_range(0, 2) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        do @(posedge i_clk); while (o_in_stall);
        if (text.len() == 0) begin
            predict_text(beat);
        end else begin
            for (int i = 0; i < text.len(); i++) begin
                ob.character  = text[i];
                ob.char_count = 4'(i + 1);
                ob.last       = (i == text.len() - 1);
                pending_chars.push_back(ob);
            end
        end
    endtask

    task automatic drain_pending();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_chars.size() != 0);
    endtask

    // Receiver side: random stall bursts while enabled.
    initial begin
        forever begin
            @(posedge i_clk);
            if (stall_bursts_on && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        i2a_pkg::t_out_beat want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (pending_chars.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORT) begin
                    $display("%0t: unexpected beat char=%h count=%0d last=%b", $realtime,
                             o_out_data.character, o_out_data.char_count, o_out_data.last);
                end
            end else begin
                want = pending_chars.pop_front();
                if (o_out_data.character !== want.character
                        || o_out_data.char_count !== want.char_count
                        || o_out_data.last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORT) begin
                        $display("%0t: expected %h/%0d/%b, got %h/%0d/%b (char/count/last)",
                                 $realtime, want.character, want.char_count, want.last,
                                 o_out_data.character, o_out_data.char_count,
                                 o_out_data.last);
                    end
                end
            end
        end
    end

    initial begin
        i2a_pkg::t_in_beat beat;
        logic [31:0]       word;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        sender_gaps_on  = 1'b1;
        stall_bursts_on = 1'b1;
        for (int r = 0; r < DIR_N; r++) begin
            send_word(dir_beats[r], dir_texts[r]);
        end
        drain_pending();

        for (int n = 0; n < RAND_N; n++) begin
            if (n % 25 == 0) begin
                sender_gaps_on  = ($urandom_range(0, 3) != 0);
                stall_bursts_on = ($urandom_range(0, 3) != 0);
            end
            if (n >= RAND_N - CALM_TAIL) begin
                sender_gaps_on  = 1'b0;
                stall_bursts_on = 1'b0;
            end
            if (n == RAND_N / 2) begin
                drain_pending();
            end
            // Bias towards short numbers and the wrap points of each format.
            case ($urandom_range(0, 5))
                0:       word = $urandom_range(0, 20);
                1:       word = 32'hFFFF_FFFF - $urandom_range(0, 20);
                2:       word = 32'h7FFF_FFF0 + $urandom_range(0, 31);
                3:       word = (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
                default: word = $urandom;
            endcase
            beat.value  = word;
            beat.action = 2'($urandom_range(0, 3));
            send_word(beat, "");
        end
        i_in_valid <= 1'b0;

        while (pending_chars.size() != 0) @(posedge i_clk);
        // Keep running after the queue empties so that any late stray beat is still caught.
        repeat (60) @(posedge i_clk);
        if (mismatch_count == 0 && pending_chars.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
